// ===== src/coap_frame_parser_unit_macros.svh =====
// Assertion macros shared by the CoAP frame parser RTL
`ifndef COAP_FRAME_PARSER_UNIT_MACROS_SVH
`define COAP_FRAME_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check that the property holds at every clock edge outside reset
`define CFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that the expression never holds outside reset
`define CFP_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`else

`define CFP_ASSERT(lbl, prop, msg)
`define CFP_NEVER(lbl, expr, msg)

`endif

`endif

// ===== src/cfp_pkg.sv =====
// Shared types and constants of the CoAP frame parser
`default_nettype none

package cfp_pkg;

    // Result queue depth (entries)
    localparam int QueueDepth = 4;

    // Result kinds
    localparam logic [2:0] K_HEADER   = 3'd0;
    localparam logic [2:0] K_TOKEN    = 3'd1;
    localparam logic [2:0] K_OPTSTART = 3'd2;
    localparam logic [2:0] K_OPTBYTE  = 3'd3;
    localparam logic [2:0] K_PAYLOAD  = 3'd4;
    localparam logic [2:0] K_DONE     = 3'd5;
    localparam logic [2:0] K_ERROR    = 3'd6;

    // Error codes
    localparam logic [1:0] E_SHORT_HDR = 2'd0;
    localparam logic [1:0] E_TRUNC_EXT = 2'd1;
    localparam logic [1:0] E_OVERRUN   = 2'd2;
    localparam logic [1:0] E_NUMBER    = 2'd3;

    // Message layout constants
    localparam logic [7:0]  PayloadMarker  = 8'hFF;
    localparam logic [3:0]  NibbleOneByte  = 4'd13;
    localparam logic [3:0]  NibbleTwoByte  = 4'd14;
    localparam logic [16:0] ExtOffsetOne   = 17'd13;
    localparam logic [16:0] ExtOffsetTwo   = 17'd269;
    localparam logic [17:0] MaxOptNumber   = 18'd65535;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  version;
        logic [1:0]  msg_type;
        logic [3:0]  token_len;
        logic [7:0]  resp_code;
        logic [15:0] message_id;
        logic [15:0] option_number;
        logic [16:0] option_length;
        logic [7:0]  data;
        logic [1:0]  error_code;
        logic        last_result;
    } cfp_item_t;

    // Results of one byte: slot 0 fills first, slot 1 only holds a frame end
    typedef struct packed {
        logic [1:0]            v;
        cfp_item_t [1:0]       item;
    } cfp_pair_t;

endpackage

`default_nettype wire

// ===== src/coap_frame_parser_unit.sv =====
// Top level of the streaming CoAP frame parser
`default_nettype none

// Streaming CoAP message parser. Takes one datagram byte per transaction
// (in_last on the final byte) and emits header, token, option start, option
// value and payload results, closing each frame with a done or error result;
// downstream is to drop all results of a frame that closes with an error,
// as the parser does not drop them itself. A byte is decoded in the cycle
// it is accepted and its results enter a queue of QUEUE_DEPTH entries (at
// least 2; 3 or more for the full rate), visible on the output in the next
// cycle. The input takes one byte per cycle while the queue has two free
// entries, so with 3 or more entries and no output stall the sustained rate
// is one byte per cycle; with 2 entries the input waits for the queue to
// empty before it takes the next byte. The final byte of a frame usually
// yields two results, and the output port delivers one result per cycle.
module coap_frame_parser_unit #(
    parameter int QUEUE_DEPTH = cfp_pkg::QueueDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [1:0]  version,
    output logic [1:0]  msg_type,
    output logic [3:0]  token_len,
    output logic [7:0]  resp_code,
    output logic [15:0] message_id,
    output logic [15:0] option_number,
    output logic [16:0] option_length,
    output logic [7:0]  data,
    output logic [1:0]  error_code,
    output logic        last_result
);
    import cfp_pkg::*;

    logic       room;
    logic       in_acc;
    cfp_pair_t  res;
    cfp_item_t  head;

    assign in_stall = !room;
    assign in_acc   = in_valid && room;

    cfp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (in_acc),
        .in_byte (in_byte),
        .in_last (in_last),
        .res     (res)
    );

    cfp_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res),
        .pop   (!out_stall),
        .head  (head),
        .valid (out_valid),
        .room  (room)
    );

    assign kind          = head.kind;
    assign version       = head.version;
    assign msg_type      = head.msg_type;
    assign token_len     = head.token_len;
    assign resp_code     = head.resp_code;
    assign message_id    = head.message_id;
    assign option_number = head.option_number;
    assign option_length = head.option_length;
    assign data          = head.data;
    assign error_code    = head.error_code;
    assign last_result   = head.last_result;

endmodule

`default_nettype wire

// ===== src/cfp_core.sv =====
// Per-byte CoAP decode: parse state registers and result generation
`default_nettype none

`include "coap_frame_parser_unit_macros.svh"

module cfp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                acc,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output cfp_pkg::cfp_pair_t  res
);
    import cfp_pkg::*;

    typedef enum logic [11:0] {
        PH_HDR     = 12'b0000_0000_0001,
        PH_TOKEN   = 12'b0000_0000_0010,
        PH_OPT     = 12'b0000_0000_0100,
        PH_D13     = 12'b0000_0000_1000,
        PH_D14A    = 12'b0000_0001_0000,
        PH_D14B    = 12'b0000_0010_0000,
        PH_L13     = 12'b0000_0100_0000,
        PH_L14A    = 12'b0000_1000_0000,
        PH_L14B    = 12'b0001_0000_0000,
        PH_VALUE   = 12'b0010_0000_0000,
        PH_PAYLOAD = 12'b0100_0000_0000,
        PH_SKIP    = 12'b1000_0000_0000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [23:0] hdr_reg, hdr_next;
    logic [3:0]  token_left_reg, token_left_next;
    logic [15:0] last_num_reg, last_num_next;
    logic [16:0] delta_reg, delta_next;
    logic [16:0] length_reg, length_next;
    logic [3:0]  pend_reg, pend_next;
    logic [16:0] value_left_reg, value_left_next;

    logic        prim_v;
    logic        term_v;
    cfp_item_t   prim;
    cfp_item_t   term;
    logic        do_start;
    logic        do_finish;
    logic [3:0]  pend_use;
    logic [16:0] delta_new;
    logic [16:0] len_new;
    logic [16:0] vl_dec;
    logic [3:0]  tl_dec;
    logic [17:0] num_sum;

    always_comb
    begin
        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        hdr_next        = hdr_reg;
        token_left_next = token_left_reg;
        last_num_next   = last_num_reg;
        delta_next      = delta_reg;
        length_next     = length_reg;
        pend_next       = pend_reg;
        value_left_next = value_left_reg;

        prim_v    = 1'b0;
        term_v    = 1'b0;
        prim      = '0;
        term      = '0;
        do_start  = 1'b0;
        do_finish = 1'b0;
        pend_use  = pend_reg;
        delta_new = delta_reg;
        len_new   = length_reg;
        num_sum   = '0;
        tl_dec    = token_left_reg - 4'd1;
        vl_dec    = (value_left_reg != '0) ? value_left_reg - 17'd1 : value_left_reg;

        case (phase_reg)
            PH_HDR:
            begin
                hdr_next = {hdr_reg[15:0], in_byte};
                if (hdr_cnt_reg == 2'd3)
                begin
                    prim_v          = 1'b1;
                    prim.kind       = K_HEADER;
                    prim.version    = hdr_reg[23:22];
                    prim.msg_type   = hdr_reg[21:20];
                    prim.token_len  = hdr_reg[19:16];
                    prim.resp_code  = hdr_reg[15:8];
                    prim.message_id = {hdr_reg[7:0], in_byte};
                    token_left_next = hdr_reg[19:16];
                    hdr_cnt_next    = 2'd0;
                    phase_next      = (hdr_reg[19:16] != 4'd0) ? PH_TOKEN : PH_OPT;
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg + 2'd1;
                end
            end
            PH_TOKEN:
            begin
                prim_v          = 1'b1;
                prim.kind       = K_TOKEN;
                prim.data       = in_byte;
                token_left_next = tl_dec;
                if (tl_dec == 4'd0)
                begin
                    phase_next = PH_OPT;
                end
            end
            PH_OPT:
            begin
                if (in_byte == PayloadMarker)
                begin
                    phase_next = PH_PAYLOAD;
                end
                else
                begin
                    pend_next = in_byte[3:0];
                    pend_use  = in_byte[3:0];
                    if (in_byte[7:4] == NibbleOneByte)
                    begin
                        phase_next = PH_D13;
                    end
                    else if (in_byte[7:4] == NibbleTwoByte)
                    begin
                        phase_next = PH_D14A;
                    end
                    else
                    begin
                        delta_new = {13'd0, in_byte[7:4]};
                        do_start  = 1'b1;
                    end
                end
            end
            PH_D13:
            begin
                delta_new = {9'd0, in_byte} + ExtOffsetOne;
                do_start  = 1'b1;
            end
            PH_D14A:
            begin
                delta_next = {1'b0, in_byte, 8'd0};
                phase_next = PH_D14B;
            end
            PH_D14B:
            begin
                delta_new = {1'b0, delta_reg[15:8], in_byte} + ExtOffsetTwo;
                do_start  = 1'b1;
            end
            PH_L13:
            begin
                len_new   = {9'd0, in_byte} + ExtOffsetOne;
                do_finish = 1'b1;
            end
            PH_L14A:
            begin
                length_next = {1'b0, in_byte, 8'd0};
                phase_next  = PH_L14B;
            end
            PH_L14B:
            begin
                len_new   = {1'b0, length_reg[15:8], in_byte} + ExtOffsetTwo;
                do_finish = 1'b1;
            end
            PH_VALUE:
            begin
                prim_v             = 1'b1;
                prim.kind          = K_OPTBYTE;
                prim.option_number = last_num_reg;
                prim.option_length = length_reg;
                prim.data          = in_byte;
                value_left_next    = vl_dec;
                if (vl_dec == '0)
                begin
                    phase_next = PH_OPT;
                end
            end
            PH_PAYLOAD:
            begin
                prim_v    = 1'b1;
                prim.kind = K_PAYLOAD;
                prim.data = in_byte;
            end
            default:
            begin
                phase_next = PH_SKIP;
            end
        endcase

        // Delta is known: pick the length form
        if (do_start)
        begin
            delta_next = delta_new;
            if (pend_use == NibbleOneByte)
            begin
                phase_next = PH_L13;
            end
            else if (pend_use == NibbleTwoByte)
            begin
                phase_next = PH_L14A;
            end
            else
            begin
                len_new   = {13'd0, pend_use};
                do_finish = 1'b1;
            end
        end

        // Option header complete: check the running number, open the value
        if (do_finish)
        begin
            length_next = len_new;
            num_sum     = {2'b00, last_num_reg} + {1'b0, delta_next};
            prim_v      = 1'b1;
            if (num_sum > MaxOptNumber)
            begin
                prim.kind       = K_ERROR;
                prim.error_code = E_NUMBER;
                phase_next      = PH_SKIP;
            end
            else
            begin
                prim.kind          = K_OPTSTART;
                prim.option_number = num_sum[15:0];
                prim.option_length = len_new;
                last_num_next      = num_sum[15:0];
                value_left_next    = len_new;
                phase_next         = (len_new != '0) ? PH_VALUE : PH_OPT;
            end
        end

        // Frame end: close with done or error (none after an earlier error), then clear per-frame state
        if (in_last)
        begin
            term_v    = (phase_next != PH_SKIP);
            term.kind = K_ERROR;
            if (phase_next == PH_HDR)
            begin
                term.error_code = E_SHORT_HDR;
            end
            else if (phase_next inside {PH_D13, PH_D14A, PH_D14B, PH_L13, PH_L14A, PH_L14B})
            begin
                term.error_code = E_TRUNC_EXT;
            end
            else if (phase_next == PH_VALUE)
            begin
                term.error_code = E_OVERRUN;
            end
            else
            begin
                term.kind = K_DONE;
            end
            phase_next      = PH_HDR;
            hdr_cnt_next    = 2'd0;
            hdr_next        = '0;
            token_left_next = '0;
            last_num_next   = '0;
            delta_next      = '0;
            length_next     = '0;
            pend_next       = '0;
            value_left_next = '0;
        end

        res.v                    = acc ? {prim_v && term_v, prim_v || term_v} : 2'b00;
        res.item[0]              = prim_v ? prim : term;
        res.item[0].last_result  = !(prim_v && term_v);
        res.item[1]              = term;
        res.item[1].last_result  = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR;
            hdr_cnt_reg    <= '0;
            hdr_reg        <= '0;
            token_left_reg <= '0;
            last_num_reg   <= '0;
            delta_reg      <= '0;
            length_reg     <= '0;
            pend_reg       <= '0;
            value_left_reg <= '0;
        end
        else if (acc)
        begin
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            hdr_reg        <= hdr_next;
            token_left_reg <= token_left_next;
            last_num_reg   <= last_num_next;
            delta_reg      <= delta_next;
            length_reg     <= length_next;
            pend_reg       <= pend_next;
            value_left_reg <= value_left_next;
        end
    end

    `CFP_ASSERT(a_pair_fill, res.v[1] |-> res.v[0], "second result without first")
    `CFP_ASSERT(a_tail_term, res.v[1] |-> (res.item[1].kind == K_DONE || res.item[1].kind == K_ERROR), "second result is not a frame end")
    `CFP_ASSERT(a_frame_end, acc && in_last |=> phase_reg == PH_HDR && hdr_cnt_reg == 2'd0, "frame end left parse state")

endmodule

`default_nettype wire

// ===== src/cfp_outq.sv =====
// Result queue: takes up to two results per cycle, delivers one while pop is high
`default_nettype none

`include "coap_frame_parser_unit_macros.svh"

module cfp_outq #(
    parameter int DEPTH = cfp_pkg::QueueDepth
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cfp_pkg::cfp_pair_t  push,
    input  logic                pop,
    output cfp_pkg::cfp_item_t  head,
    output logic                valid,
    output logic                room
);
    import cfp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cfp_item_t       mem_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [PW-1:0]   wr_inc1;
    logic [PW-1:0]   wr_inc2;
    logic            do_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign wr_inc1 = ptr_inc(wr_reg);
    assign wr_inc2 = ptr_inc(wr_inc1);
    assign do_pop  = pop && valid;
    assign valid   = (cnt_reg != '0);
    assign room    = (cnt_reg <= CW'(DEPTH - 2));
    assign head    = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push.v[1] ? wr_inc2 : (push.v[0] ? wr_inc1 : wr_reg);
        rd_next  = do_pop ? ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + CW'(push.v[0]) + CW'(push.v[1]) - CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.v[0])
        begin
            mem_reg[wr_reg] <= push.item[0];
        end
        if (push.v[1])
        begin
            mem_reg[wr_inc1] <= push.item[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    `CFP_NEVER(a_cnt_range, cnt_reg > CW'(DEPTH), "queue count beyond depth")
    `CFP_ASSERT(a_push_room, push.v[0] |-> room, "push without two free entries")
    `CFP_ASSERT(a_ptr_match, (cnt_reg == '0 || cnt_reg == CW'(DEPTH)) |-> wr_reg == rd_reg, "queue pointers disagree with count")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the streaming CoAP frame parser
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cfp_pkg::*;

    localparam int          SCRAMBLED_BYTES = 1900;
    localparam int          IDLE_LIMIT      = 2000;
    localparam int          DRAIN_CYCLES    = 20;
    localparam int          HOLD_START      = 700;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          RX_CALM_FIRST   = 1600;
    localparam int          RX_CALM_LAST    = 2000;
    localparam int          TX_CALM_FIRST   = 1000;
    localparam int          TX_CALM_LAST    = 1300;
    // Directed rows carry a typed-in kind only where it is obvious
    localparam logic [2:0]  NO_KIND         = 3'd7;
    localparam logic [1:0]  NO_CODE         = 2'd0;

    typedef enum logic [3:0] {
        P_HEADER,
        P_TOKEN,
        P_OPTION,
        P_DELTA1,
        P_DELTA2HI,
        P_DELTA2LO,
        P_LEN1,
        P_LEN2HI,
        P_LEN2LO,
        P_VALUE,
        P_PAYLOAD,
        P_DISCARD
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] b;
        logic       lst;
        logic [2:0] k;
        logic [1:0] code;
    } dir_row_t;

    localparam int DIR_COUNT = 27;
    localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
        // frame of one byte
        '{8'h40, 1'b1, K_ERROR,  E_SHORT_HDR},
        // header FF 00 FF FF, token length 15, frame ends inside the token
        '{8'hFF, 1'b0, NO_KIND,  NO_CODE},
        '{8'h00, 1'b0, NO_KIND,  NO_CODE},
        '{8'hFF, 1'b0, NO_KIND,  NO_CODE},
        '{8'hFF, 1'b0, K_HEADER, NO_CODE},
        '{8'hFF, 1'b1, K_DONE,   NO_CODE},
        // two-byte delta at its maximum pushes the number past 65535
        '{8'h40, 1'b0, NO_KIND,  NO_CODE},
        '{8'h01, 1'b0, NO_KIND,  NO_CODE},
        '{8'h00, 1'b0, NO_KIND,  NO_CODE},
        '{8'h00, 1'b0, K_HEADER, NO_CODE},
        '{8'hE0, 1'b0, NO_KIND,  NO_CODE},
        '{8'hFF, 1'b0, NO_KIND,  NO_CODE},
        '{8'hFF, 1'b1, K_ERROR,  E_NUMBER},
        // frame ends right after a one-byte delta nibble
        '{8'h40, 1'b0, NO_KIND,  NO_CODE},
        '{8'h00, 1'b0, NO_KIND,  NO_CODE},
        '{8'h00, 1'b0, NO_KIND,  NO_CODE},
        '{8'h00, 1'b0, NO_KIND,  NO_CODE},
        '{8'hD0, 1'b1, K_ERROR,  E_TRUNC_EXT},
        // option 1 with one value byte, then two payload bytes
        '{8'h40, 1'b0, NO_KIND,  NO_CODE},
        '{8'h02, 1'b0, NO_KIND,  NO_CODE},
        '{8'hAB, 1'b0, NO_KIND,  NO_CODE},
        '{8'hCD, 1'b0, K_HEADER, NO_CODE},
        '{8'h11, 1'b0, NO_KIND,  NO_CODE},
        '{8'h7A, 1'b0, NO_KIND,  NO_CODE},
        '{8'hFF, 1'b0, NO_KIND,  NO_CODE},
        '{8'h55, 1'b0, NO_KIND,  NO_CODE},
        '{8'h00, 1'b1, K_DONE,   NO_CODE}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        in_last;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic [1:0]  version;
    logic [1:0]  msg_type;
    logic [3:0]  token_len;
    logic [7:0]  resp_code;
    logic [15:0] message_id;
    logic [15:0] option_number;
    logic [16:0] option_length;
    logic [7:0]  data;
    logic [1:0]  error_code;
    logic        last_result;

    coap_frame_parser_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .in_last       (in_last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .version       (version),
        .msg_type      (msg_type),
        .token_len     (token_len),
        .resp_code     (resp_code),
        .message_id    (message_id),
        .option_number (option_number),
        .option_length (option_length),
        .data          (data),
        .error_code    (error_code),
        .last_result   (last_result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decoder state of the expected-behavior model
    parse_phase_t frame_phase;
    logic [1:0]   hdr_count;
    logic [31:0]  hdr_bytes;
    logic [3:0]   tok_left;
    int unsigned  opt_number;
    int unsigned  delta_sum;
    int unsigned  len_sum;
    logic [3:0]   held_len_nib;
    int unsigned  val_left;

    cfp_item_t    byte_results[$];
    cfp_item_t    pending_results[$];
    logic [7:0]   stim_byte[$];
    logic         stim_last[$];
    logic [2:0]   stim_kind[$];
    logic [1:0]   stim_code[$];
    int           fails = 0;
    int           idle_cycles = 0;
    int           rx_cycles = 0;

    function automatic cfp_item_t blank_item(input logic [2:0] k);
        cfp_item_t it;
        it = '0;
        it.kind = k;
        return it;
    endfunction

    task automatic clear_frame();
        frame_phase  = P_HEADER;
        hdr_count    = '0;
        hdr_bytes    = '0;
        tok_left     = '0;
        opt_number   = 0;
        delta_sum    = 0;
        len_sum      = 0;
        held_len_nib = '0;
        val_left     = 0;
    endtask

    task automatic flag_error(input logic [1:0] code);
        cfp_item_t it;
        it = blank_item(K_ERROR);
        it.error_code = code;
        byte_results.push_back(it);
        frame_phase = P_DISCARD;
    endtask

    task automatic close_option();
        int unsigned num;
        cfp_item_t   it;
        num = opt_number + delta_sum;
        if (num > MaxOptNumber)
        begin
            // the number is checked before any option start goes out
            flag_error(E_NUMBER);
        end
        else
        begin
            it = blank_item(K_OPTSTART);
            it.option_number = num[15:0];
            it.option_length = len_sum[16:0];
            byte_results.push_back(it);
            opt_number  = num;
            val_left    = len_sum;
            frame_phase = (len_sum != 0) ? P_VALUE : P_OPTION;
        end
    endtask

    task automatic begin_length();
        if (held_len_nib == NibbleOneByte)
            frame_phase = P_LEN1;
        else if (held_len_nib == NibbleTwoByte)
            frame_phase = P_LEN2HI;
        else
        begin
            len_sum = held_len_nib;
            close_option();
        end
    endtask

    // Work out the results that one accepted byte causes
    task automatic decode_byte(input logic [7:0] b, input logic lst);
        cfp_item_t it;
        byte_results.delete();
        case (frame_phase)
            P_HEADER:
            begin
                hdr_bytes = {hdr_bytes[23:0], b};
                if (hdr_count == 2'd3)
                begin
                    it = blank_item(K_HEADER);
                    it.version    = hdr_bytes[31:30];
                    it.msg_type   = hdr_bytes[29:28];
                    it.token_len  = hdr_bytes[27:24];
                    it.resp_code  = hdr_bytes[23:16];
                    it.message_id = hdr_bytes[15:0];
                    byte_results.push_back(it);
                    tok_left    = hdr_bytes[27:24];
                    hdr_count   = '0;
                    frame_phase = (tok_left != 0) ? P_TOKEN : P_OPTION;
                end
                else
                    hdr_count = hdr_count + 2'd1;
            end
            P_TOKEN:
            begin
                it = blank_item(K_TOKEN);
                it.data = b;
                byte_results.push_back(it);
                tok_left = tok_left - 4'd1;
                if (tok_left == 0)
                    frame_phase = P_OPTION;
            end
            P_OPTION:
            begin
                if (b == PayloadMarker)
                    frame_phase = P_PAYLOAD;
                else
                begin
                    held_len_nib = b[3:0];
                    if (b[7:4] == NibbleOneByte)
                        frame_phase = P_DELTA1;
                    else if (b[7:4] == NibbleTwoByte)
                        frame_phase = P_DELTA2HI;
                    else
                    begin
                        delta_sum = b[7:4];
                        begin_length();
                    end
                end
            end
            P_DELTA1:
            begin
                delta_sum = b + ExtOffsetOne;
                begin_length();
            end
            P_DELTA2HI:
            begin
                delta_sum   = {b, 8'h00};
                frame_phase = P_DELTA2LO;
            end
            P_DELTA2LO:
            begin
                delta_sum = (delta_sum | b) + ExtOffsetTwo;
                begin_length();
            end
            P_LEN1:
            begin
                len_sum = b + ExtOffsetOne;
                close_option();
            end
            P_LEN2HI:
            begin
                len_sum     = {b, 8'h00};
                frame_phase = P_LEN2LO;
            end
            P_LEN2LO:
            begin
                len_sum = (len_sum | b) + ExtOffsetTwo;
                close_option();
            end
            P_VALUE:
            begin
                it = blank_item(K_OPTBYTE);
                it.option_number = opt_number[15:0];
                it.option_length = len_sum[16:0];
                it.data          = b;
                byte_results.push_back(it);
                if (val_left != 0)
                    val_left = val_left - 1;
                if (val_left == 0)
                    frame_phase = P_OPTION;
            end
            P_PAYLOAD:
            begin
                it = blank_item(K_PAYLOAD);
                it.data = b;
                byte_results.push_back(it);
            end
            default:
                frame_phase = P_DISCARD;
        endcase

        if (lst)
        begin
            if (frame_phase == P_HEADER)
                flag_error(E_SHORT_HDR);
            else if (frame_phase >= P_DELTA1 && frame_phase <= P_LEN2LO)
                flag_error(E_TRUNC_EXT);
            else if (frame_phase == P_VALUE)
                flag_error(E_OVERRUN);
            else if (frame_phase != P_DISCARD)
                byte_results.push_back(blank_item(K_DONE));
            clear_frame();
        end

        if (byte_results.size() > 0)
        begin
            it = byte_results.pop_back();
            it.last_result = 1'b1;
            byte_results.push_back(it);
        end
    endtask

    // Append one datagram: mostly well-formed, some cut short, some noise
    task automatic add_random_frame();
        logic [7:0]  fb[$];
        logic [7:0]  hb;
        logic [3:0]  dnib;
        logic [3:0]  lnib;
        logic [15:0] dext;
        logic [15:0] lext;
        int unsigned pick;
        int unsigned tkl;
        int unsigned nopt;
        int unsigned vlen;
        int unsigned cut;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            repeat ($urandom_range(8, 1)) fb.push_back(8'($urandom_range(255)));
        end
        else
        begin
            tkl = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(4);
            hb = 8'($urandom_range(255));
            hb[3:0] = 4'(tkl);
            fb.push_back(hb);
            repeat (3) fb.push_back(8'($urandom_range(255)));
            repeat (tkl) fb.push_back(8'($urandom_range(255)));
            nopt = $urandom_range(4);
            for (int o = 0; o < nopt; o++)
            begin
                dext = '0;
                lext = '0;
                pick = $urandom_range(99);
                if (pick < 60)
                    dnib = 4'($urandom_range(12));
                else if (pick < 78)
                begin
                    dnib = NibbleOneByte;
                    dext = 16'($urandom_range(255));
                end
                else if (pick < 88)
                begin
                    dnib = NibbleTwoByte;
                    dext = 16'($urandom_range(300));
                end
                else if (pick < 93)
                begin
                    // large two-byte deltas can overflow the option number
                    dnib = NibbleTwoByte;
                    dext = ($urandom_range(1) != 0) ? 16'hFFFF - 16'($urandom_range(300))
                                                    : 16'($urandom_range(65535));
                end
                else
                    dnib = 4'hF;
                pick = $urandom_range(99);
                if (pick < 72)
                begin
                    lnib = 4'($urandom_range(12));
                    vlen = lnib;
                end
                else if (pick < 90)
                begin
                    lnib = NibbleOneByte;
                    lext = 16'($urandom_range(20));
                    vlen = lext + ExtOffsetOne;
                end
                else if (pick < 99)
                begin
                    lnib = 4'hF;
                    vlen = 15;
                end
                else
                begin
                    lnib = NibbleTwoByte;
                    lext = 16'($urandom_range(6));
                    vlen = lext + ExtOffsetTwo;
                end
                fb.push_back({dnib, lnib});
                if (dnib == NibbleTwoByte)
                    fb.push_back(dext[15:8]);
                if (dnib == NibbleOneByte || dnib == NibbleTwoByte)
                    fb.push_back(dext[7:0]);
                if (lnib == NibbleTwoByte)
                    fb.push_back(lext[15:8]);
                if (lnib == NibbleOneByte || lnib == NibbleTwoByte)
                    fb.push_back(lext[7:0]);
                repeat (vlen) fb.push_back(8'($urandom_range(255)));
            end
            if ($urandom_range(2) != 0)
            begin
                fb.push_back(PayloadMarker);
                repeat ($urandom_range(6)) fb.push_back(8'($urandom_range(255)));
            end
            // cut the datagram short now and then
            if ($urandom_range(99) < 15 && fb.size() > 1)
            begin
                cut = $urandom_range(fb.size() - 1, 1);
                fb = fb[0:cut-1];
            end
        end
        foreach (fb[i])
        begin
            stim_byte.push_back(fb[i]);
            stim_last.push_back(i == fb.size() - 1);
            stim_kind.push_back(NO_KIND);
            stim_code.push_back(NO_CODE);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    // Result side: compare each transaction with the oldest expectation
    always @(posedge clk)
    begin
        cfp_item_t got;
        cfp_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {kind, version, msg_type, token_len, resp_code, message_id,
                   option_number, option_length, data, error_code, last_result};
            if (pending_results.size() == 0)
            begin
                $error("kind: expected no result, got 0x%0h", got.kind);
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, got.kind);
                check_field("version", want.version, got.version);
                check_field("msg_type", want.msg_type, got.msg_type);
                check_field("token_len", want.token_len, got.token_len);
                check_field("resp_code", want.resp_code, got.resp_code);
                check_field("message_id", want.message_id, got.message_id);
                check_field("option_number", want.option_number, got.option_number);
                check_field("option_length", want.option_length, got.option_length);
                check_field("data", want.data, got.data);
                check_field("error_code", want.error_code, got.error_code);
                check_field("last_result", want.last_result, got.last_result);
            end
        end
    end

    // Receiver: random stalls, one long hold-off, one calm stretch
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycles++;
            if (rx_cycles == HOLD_START)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_cycles += HOLD_CYCLES;
            end
            if (rx_cycles >= RX_CALM_FIRST && rx_cycles < RX_CALM_LAST)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 19);
        end
    end

    // Abort when nothing moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Sender and end of run
    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_byte  <= '0;
        in_last  <= 1'b0;
        clear_frame();
        foreach (DIR_ROWS[r])
        begin
            stim_byte.push_back(DIR_ROWS[r].b);
            stim_last.push_back(DIR_ROWS[r].lst);
            stim_kind.push_back(DIR_ROWS[r].k);
            stim_code.push_back(DIR_ROWS[r].code);
        end
        while (stim_byte.size() < DIR_COUNT + SCRAMBLED_BYTES)
            add_random_frame();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < stim_byte.size(); i++)
        begin
            while (!(i >= TX_CALM_FIRST && i < TX_CALM_LAST) && $urandom_range(99) < 19)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_byte  <= stim_byte[i];
            in_last  <= stim_last[i];
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            decode_byte(stim_byte[i], stim_last[i]);
            foreach (byte_results[j])
                pending_results.push_back(byte_results[j]);
            if (stim_kind[i] != NO_KIND)
            begin
                if (byte_results.size() == 0
                    || byte_results[byte_results.size() - 1].kind != stim_kind[i]
                    || (stim_kind[i] == K_ERROR
                        && byte_results[byte_results.size() - 1].error_code != stim_code[i]))
                begin
                    $error("kind: directed byte %0d, expected 0x%0h code 0x%0h",
                           i, stim_kind[i], stim_code[i]);
                    fails++;
                end
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        // catch stray results after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/cfp_pkg.sv
src/cfp_core.sv
src/cfp_outq.sv
src/coap_frame_parser_unit.sv
tb/sv/tb_top.sv
